FILE: rtl/core/gregorian_date_register_core_macros.svh
// ---------------------------------------------------------------------------
// Gregorian date register assertion macros
// Shared macros for the concurrent checks of the date register core.
// ---------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_REGISTER_CORE_MACROS_SVH
`define GREGORIAN_DATE_REGISTER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define GDR_ASSERT_SAME(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("date register check failed");

`define GDR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("date register check failed");

`else

`define GDR_ASSERT_SAME(lbl, ck, rn, ante, cons)

`define GDR_ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

FILE: rtl/core/gdr_pkg.sv
// ---------------------------------------------------------------------------
// Gregorian date register package
// Operation codes, calendar constants, tables and controller interface types.
// ---------------------------------------------------------------------------
`default_nettype none

package gdr_pkg;

  localparam logic [2:0] OP_SET_DATE  = 3'd0;
  localparam logic [2:0] OP_SET_MONTH = 3'd1;
  localparam logic [2:0] OP_SET_YEAR  = 3'd2;
  localparam logic [2:0] OP_SET_DAY   = 3'd3;
  localparam logic [2:0] OP_ADVANCE   = 3'd4;

  localparam int          DEFAULT_YEAR = 1900;
  localparam logic [8:0]  DAYS_LEAP    = 9'd366;
  localparam logic [8:0]  DAYS_COMMON  = 9'd365;
  localparam logic [3:0]  MONTH_JAN    = 4'd1;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [3:0]  MONTH_DEC    = 4'd12;
  localparam logic [4:0]  DAY_FIRST    = 5'd1;
  localparam logic [4:0]  DAY_LAST_DEC = 5'd31;
  localparam logic [5:0]  MOD25        = 6'd25;
  localparam logic [4:0]  MOD25_TOP    = 5'd24;

  // Reciprocal of 25 scaled by 2^35, exact for every 32-bit year.
  localparam logic [30:0] RECIP25       = 31'h51EB851F;
  localparam int          RECIP25_SHIFT = 35;

  typedef struct packed {
    logic capture;
    logic setup;
    logic mod_step;
    logic day_chk;
    logic adv_step;
    logic out_load;
  } gdr_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       mod_last;
    logic       adv_done;
  } gdr_sts_t;

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic lp);
    logic [4:0] len;
    case (m)
      4'd2:                      len = lp ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [3:0] m);
    logic [8:0] d;
    case (m)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gdr_ctrl.sv
// ---------------------------------------------------------------------------
// Gregorian date register controller
// Sequences capture, update, year residue, day check, advance and output load.
// ---------------------------------------------------------------------------
`default_nettype none

module gdr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output gdr_pkg::gdr_cmd_t      cmd,
  input  wire gdr_pkg::gdr_sts_t sts
);
  import gdr_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_MOD   = 6'b000100,
    S_DAY   = 6'b001000,
    S_ADV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.op == OP_SET_DATE || sts.op == OP_SET_YEAR) begin
          state_nxt = S_MOD;
        end else if (sts.op == OP_SET_DAY) begin
          state_nxt = S_DAY;
        end else if (sts.op == OP_ADVANCE) begin
          state_nxt = S_ADV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = (sts.op == OP_SET_DATE) ? S_DAY : S_OUT;
        end
      end
      S_DAY: begin
        cmd.day_chk = 1'b1;
        state_nxt   = S_OUT;
      end
      S_ADV: begin
        if (sts.adv_done) begin
          state_nxt = S_OUT;
        end else begin
          cmd.adv_step = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/gdr_datapath.sv
// ---------------------------------------------------------------------------
// Gregorian date register datapath
// Date state, year residue unit, month-step advance and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module gdr_datapath #(
  parameter int YEAR_BITS  = 16,
  parameter int COUNT_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [2:0]            in_op,
  input  wire logic [3:0]            in_month,
  input  wire logic [4:0]            in_day,
  input  wire logic [YEAR_BITS-1:0]  in_year,
  input  wire logic [COUNT_BITS-1:0] in_count,
  input  wire gdr_pkg::gdr_cmd_t     cmd,
  output gdr_pkg::gdr_sts_t          sts,
  output logic [3:0]                 res_month,
  output logic [4:0]                 res_day,
  output logic [YEAR_BITS-1:0]       res_year,
  output logic                       res_leap,
  output logic [4:0]                 res_days_in_month,
  output logic [8:0]                 res_day_of_year,
  output logic [8:0]                 res_days_left,
  output logic                       res_overflow
);
  import gdr_pkg::*;

  localparam int NW  = (COUNT_BITS > 5) ? COUNT_BITS : 5;

  logic [2:0]            op_r;
  logic [3:0]            mon_in_r;
  logic [4:0]            day_in_r;
  logic [YEAR_BITS-1:0]  year_in_r;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;

  logic [3:0]            month_r, month_nxt;
  logic [4:0]            day_r, day_nxt;
  logic [YEAR_BITS-1:0]  year_r, year_nxt;
  logic [4:0]            r25_r, r25_nxt;
  logic [27:0]           quo_r, quo_nxt;
  logic                  mod_ph_r, mod_ph_nxt;
  logic                  ovf_r, ovf_nxt;

  logic [YEAR_BITS-1:0]  year_chk;
  logic [3:0]            mon_chk;
  logic                  lp;
  logic [4:0]            len;
  logic [4:0]            gap;
  logic [NW-1:0]         n_ext;
  logic [NW-1:0]         step;
  logic [31:0]           year32;
  logic [27:0]           quo_calc;
  logic [31:0]           back;
  logic [4:0]            r25_calc;
  logic [8:0]            doy;
  logic [8:0]            total;

  assign year_chk = (year_in_r == '0) ? YEAR_BITS'(DEFAULT_YEAR) : year_in_r;
  assign mon_chk  = (mon_in_r >= MONTH_JAN && mon_in_r <= MONTH_DEC) ? mon_in_r : MONTH_JAN;
  assign lp       = (year_r[1:0] == 2'b00) && (r25_r != 5'd0 || year_r[3:0] == 4'd0);
  assign len      = month_days(month_r, lp);
  assign gap      = (day_r <= len) ? 5'(len - day_r) : 5'd0;
  assign n_ext    = NW'(cnt_r);
  assign step     = NW'(gap) + NW'(1);
  assign year32   = 32'(year_r);
  assign quo_calc = 28'((63'(year32) * 63'(RECIP25)) >> RECIP25_SHIFT);
  assign back     = 32'(quo_r) * 32'(MOD25);
  assign r25_calc = 5'(year32 - back);

  always_comb begin
    cnt_nxt    = cnt_r;
    month_nxt  = month_r;
    day_nxt    = day_r;
    year_nxt   = year_r;
    r25_nxt    = r25_r;
    quo_nxt    = quo_r;
    mod_ph_nxt = mod_ph_r;
    ovf_nxt    = ovf_r;
    if (cmd.capture) begin
      cnt_nxt = in_count;
    end
    if (cmd.setup) begin
      ovf_nxt    = 1'b0;
      mod_ph_nxt = 1'b0;
      if (op_r == OP_SET_DATE || op_r == OP_SET_YEAR) begin
        year_nxt = year_chk;
      end
      if (op_r == OP_SET_DATE || op_r == OP_SET_MONTH) begin
        month_nxt = mon_chk;
      end
    end
    if (cmd.mod_step) begin
      if (!mod_ph_r) begin
        quo_nxt    = quo_calc;
        mod_ph_nxt = 1'b1;
      end else begin
        r25_nxt = r25_calc;
      end
    end
    if (cmd.day_chk) begin
      day_nxt = (day_in_r >= DAY_FIRST && day_in_r <= len) ? day_in_r : DAY_FIRST;
    end
    if (cmd.adv_step) begin
      if (n_ext <= NW'(gap)) begin
        day_nxt = day_r + 5'(n_ext);
        cnt_nxt = '0;
      end else if (month_r >= MONTH_DEC) begin
        if (&year_r) begin
          month_nxt = MONTH_DEC;
          day_nxt   = DAY_LAST_DEC;
          ovf_nxt   = 1'b1;
          cnt_nxt   = '0;
        end else begin
          month_nxt = MONTH_JAN;
          day_nxt   = DAY_FIRST;
          year_nxt  = year_r + YEAR_BITS'(1);
          r25_nxt   = (r25_r == MOD25_TOP) ? 5'd0 : r25_r + 5'd1;
          cnt_nxt   = COUNT_BITS'(n_ext - step);
        end
      end else begin
        month_nxt = month_r + 4'd1;
        day_nxt   = DAY_FIRST;
        cnt_nxt   = COUNT_BITS'(n_ext - step);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      month_r  <= MONTH_JAN;
      day_r    <= DAY_FIRST;
      year_r   <= YEAR_BITS'(DEFAULT_YEAR);
      r25_r    <= 5'(DEFAULT_YEAR % 25);
      mod_ph_r <= 1'b0;
      ovf_r    <= 1'b0;
      cnt_r    <= '0;
    end else begin
      month_r  <= month_nxt;
      day_r    <= day_nxt;
      year_r   <= year_nxt;
      r25_r    <= r25_nxt;
      mod_ph_r <= mod_ph_nxt;
      ovf_r    <= ovf_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    if (cmd.capture) begin
      op_r      <= in_op;
      mon_in_r  <= in_month;
      day_in_r  <= in_day;
      year_in_r <= in_year;
    end
  end

  assign sts.op       = op_r;
  assign sts.mod_last = mod_ph_r;
  assign sts.adv_done = (cnt_r == '0);

  assign doy   = days_before(month_r) + 9'(day_r) + 9'(lp && month_r > MONTH_FEB);
  assign total = lp ? DAYS_LEAP : DAYS_COMMON;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_month         <= month_r;
      res_day           <= day_r;
      res_year          <= year_r;
      res_leap          <= lp;
      res_days_in_month <= len;
      res_day_of_year   <= doy;
      res_days_left     <= (doy <= total) ? 9'(total - doy) : 9'd0;
      res_overflow      <= ovf_r;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/gregorian_date_register_core.sv
// ---------------------------------------------------------------------------
// Gregorian date register core
// Holds one calendar date and applies set and advance requests to it.
// ---------------------------------------------------------------------------
// Each request on the in_ channel carries an op code with month, day, year
// and count fields; each produces exactly one result on the out_ channel with
// the date, leap flag, month length, day of year, days left and overflow.
// A request is taken only while the core is idle; a result may still wait in
// the output register while the next request is taken.
// After acceptance, set month and unused op codes pass only setup and output
// load; set year adds the year residue (quotient, then remainder), set day
// the day check and set date both. An advance adds one step per month stepped
// through. The next request is taken in the cycle after the result is loaded.
// Reset sets the date to January 1, 1900 and empties the output register.
// When the receiver stalls, the result holds and the core finishes at most
// one more request before it waits for the output register to free.
// ---------------------------------------------------------------------------
`default_nettype none

`include "gregorian_date_register_core_macros.svh"

module gregorian_date_register_core #(
  parameter int YEAR_BITS  = 16,
  parameter int COUNT_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [2:0]            in_op,
  input  wire logic [3:0]            in_month_in,
  input  wire logic [4:0]            in_day_in,
  input  wire logic [YEAR_BITS-1:0]  in_year_in,
  input  wire logic [COUNT_BITS-1:0] in_count,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [3:0]                 out_month_out,
  output logic [4:0]                 out_day_out,
  output logic [YEAR_BITS-1:0]       out_year_out,
  output logic                       out_is_leap,
  output logic [4:0]                 out_days_in_month,
  output logic [8:0]                 out_day_of_year,
  output logic [8:0]                 out_days_left,
  output logic                       out_overflow
);
  import gdr_pkg::*;

  gdr_cmd_t cmd;
  gdr_sts_t sts;
  logic     month_ok;
  logic     len_ok;
  logic     ovf_date_ok;

  gdr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  gdr_datapath #(
    .YEAR_BITS  (YEAR_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_op             (in_op),
    .in_month          (in_month_in),
    .in_day            (in_day_in),
    .in_year           (in_year_in),
    .in_count          (in_count),
    .cmd               (cmd),
    .sts               (sts),
    .res_month         (out_month_out),
    .res_day           (out_day_out),
    .res_year          (out_year_out),
    .res_leap          (out_is_leap),
    .res_days_in_month (out_days_in_month),
    .res_day_of_year   (out_day_of_year),
    .res_days_left     (out_days_left),
    .res_overflow      (out_overflow)
  );

  assign month_ok    = (out_month_out >= MONTH_JAN) && (out_month_out <= MONTH_DEC);
  assign len_ok      = (out_days_in_month >= 5'd28) && (out_days_in_month <= 5'd31);
  assign ovf_date_ok = (out_month_out == MONTH_DEC) && (out_day_out == DAY_LAST_DEC) &&
                       (&out_year_out);

  `GDR_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `GDR_ASSERT_SAME(a_month_range, clk, rst_n, out_valid, month_ok)
  `GDR_ASSERT_SAME(a_len_range, clk, rst_n, out_valid, len_ok)
  `GDR_ASSERT_SAME(a_overflow_date, clk, rst_n, out_valid && out_overflow, ovf_date_ok)

endmodule

`default_nettype wire
